// ===== design/lvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lvc_pkg: shared types and constants for the LRU vertex cache simulator
// Holds the field widths, reset values and the wavefront record that travels
// down the row of cache cells.
// ----------------------------------------------------------------------------
package lvc_pkg;

    localparam int MAX_CAPACITY_DEF = 128;
    localparam int KEY_W            = 16;
    localparam int CNT_W            = 24;
    localparam int POS_OUT_W        = 7;
    localparam int CFG_W            = 8;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 8'd16;
    localparam logic [CNT_W-1:0] COUNT_MAX      = 24'hFF_FFFF;

    // One lookup in flight: the key, the value being pushed back through the
    // cells, and whether the key has already been found further up the row.
    typedef struct packed {
        logic             active;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] carry;
        logic             carry_vld;
        logic             found;
        logic             last;
    } wave_t;

endpackage

// ===== design/lvc_cell.sv =====
// ----------------------------------------------------------------------------
// lvc_cell: one slot of the move-to-front cache
// Compares the passing lookup against its entry, swaps in the carried value
// and registers the lookup to hand it on to the next slot.
// ----------------------------------------------------------------------------
module lvc_cell #(
    parameter int MAX_CAPACITY = lvc_pkg::MAX_CAPACITY_DEF,
    parameter int CELL_IDX     = 0,
    parameter int CAP_W        = $clog2(MAX_CAPACITY + 1),
    parameter int POS_W        = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [CAP_W-1:0]     eff_cap,
    input  lvc_pkg::wave_t       wave_i,
    input  logic [POS_W-1:0]     pos_i,
    output lvc_pkg::wave_t       wave_o,
    output logic [POS_W-1:0]     pos_o
);
    import lvc_pkg::*;

    localparam logic [CAP_W-1:0] IDX_CAP = CAP_W'(CELL_IDX);
    localparam logic [POS_W-1:0] IDX_POS = POS_W'(CELL_IDX);

    logic [KEY_W-1:0] entry_reg, entry_next;
    logic             valid_reg, valid_next;
    wave_t            wave_reg, wave_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             in_use;
    logic             hit_here;

    assign in_use   = (IDX_CAP < eff_cap);
    assign hit_here = wave_i.active && in_use && !wave_i.found && valid_reg &&
                      (entry_reg == wave_i.key);

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        wave_next  = wave_i;
        pos_next   = pos_i;
        if (wave_i.active) begin
            if (!in_use) begin
                // slots past the capacity are forgotten
                valid_next = 1'b0;
            end else if (!wave_i.found) begin
                entry_next = wave_i.carry;
                valid_next = wave_i.carry_vld;
                if (hit_here) begin
                    wave_next.found     = 1'b1;
                    wave_next.carry_vld = 1'b0;
                    pos_next            = IDX_POS;
                end else begin
                    wave_next.carry     = entry_reg;
                    wave_next.carry_vld = valid_reg;
                end
            end
            if (wave_i.last) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            wave_reg  <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            entry_reg <= entry_next;
            pos_reg   <= pos_next;
        end
    end

    assign wave_o = wave_reg;
    assign pos_o  = pos_reg;

endmodule

// ===== design/lvc_tally.sv =====
// ----------------------------------------------------------------------------
// lvc_tally: hit and miss counters and result register
// Counts each finished lookup with saturation, clears after the last beat of
// a buffer and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module lvc_tally #(
    parameter int POS_W = 7
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lvc_pkg::wave_t                wave_i,
    input  logic [POS_W-1:0]              pos_i,
    output logic                          advance,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [lvc_pkg::POS_OUT_W-1:0] m_hit_position,
    output logic [lvc_pkg::CNT_W-1:0]     m_hit_total,
    output logic [lvc_pkg::CNT_W-1:0]     m_miss_total,
    output logic                          m_is_last
);
    import lvc_pkg::*;

    logic [CNT_W-1:0]         hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]         miss_cnt_reg, miss_cnt_next;
    logic                     m_valid_reg;
    logic                     hit_reg;
    logic [POS_OUT_W-1:0]     pos_out_reg;
    logic [CNT_W-1:0]         hit_total_reg, miss_total_reg;
    logic                     last_reg;
    logic [POS_W+POS_OUT_W-1:0] pos_wide;

    assign advance  = !m_valid_reg || m_ready;
    assign pos_wide = {{POS_OUT_W{1'b0}}, pos_i};

    always_comb begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (wave_i.found) begin
            if (hit_cnt_reg != COUNT_MAX) begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end else begin
            if (miss_cnt_reg != COUNT_MAX) begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= wave_i.active;
            if (wave_i.active) begin
                hit_cnt_reg  <= wave_i.last ? '0 : hit_cnt_next;
                miss_cnt_reg <= wave_i.last ? '0 : miss_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && wave_i.active) begin
            hit_reg        <= wave_i.found;
            pos_out_reg    <= wave_i.found ? pos_wide[POS_OUT_W-1:0] : '0;
            hit_total_reg  <= hit_cnt_next;
            miss_total_reg <= miss_cnt_next;
            last_reg       <= wave_i.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = hit_reg;
    assign m_hit_position = pos_out_reg;
    assign m_hit_total    = hit_total_reg;
    assign m_miss_total   = miss_total_reg;
    assign m_is_last      = last_reg;

endmodule

// ===== design/lru_vertex_cache_sim_top.sv =====
// ----------------------------------------------------------------------------
// lru_vertex_cache_sim_top: move-to-front vertex cache hit-rate simulator
// A row of MAX_CAPACITY cache cells through which each lookup travels as a
// wavefront, followed by the saturating hit and miss counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (s_valid/s_ready) carry a 16-bit vertex index and a flag for
//   the last index of a buffer. Result beats (m_valid/m_ready) carry the hit
//   flag, the slot it hit in (0 on a miss) and the running hit and miss
//   counts, this beat included, plus the echoed last flag.
//   cfg_valid/cfg_ready/cfg_data write the capacity (0 counts as 1, values
//   above MAX_CAPACITY as MAX_CAPACITY); write it only while no lookup is in
//   flight. cfg_ready is always high.
//   Each lookup passes every cell register in turn, then the result register.
//   Throughput: while no result stalls, one cell per cycle and one beat per
//   cycle, since each lookup trails the previous one by one cell.
//   Reset: all slots empty, counters zero, capacity 16. After a beat marked
//   last, the cells it passes are emptied and the counters clear, so the
//   following beat starts a fresh buffer.
//   Stall: while a result waits on m_ready the whole row holds and s_ready
//   drops; a free result register lets the row keep moving.
// ----------------------------------------------------------------------------
module lru_vertex_cache_sim_top #(
    parameter int MAX_CAPACITY = lvc_pkg::MAX_CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lvc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lvc_pkg::KEY_W-1:0]     s_vertex_index,
    input  logic                          s_last_in_buffer,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [lvc_pkg::POS_OUT_W-1:0] m_hit_position,
    output logic [lvc_pkg::CNT_W-1:0]     m_hit_total,
    output logic [lvc_pkg::CNT_W-1:0]     m_miss_total,
    output logic                          m_is_last
);
    import lvc_pkg::*;

    localparam int CAP_W = $clog2(MAX_CAPACITY + 1);
    localparam int POS_W = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int CMP_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;

    logic [CFG_W-1:0] capacity_reg;
    logic [CMP_W-1:0] cap_wide;
    logic [CAP_W-1:0] eff_cap;
    logic             advance;

    // wave_chain[i] feeds cell i; the last element feeds the counters
    wave_t            wave_chain [0:MAX_CAPACITY];
    logic [POS_W-1:0] pos_chain  [0:MAX_CAPACITY];

    // Capacity register: always ready, clamp on the way out
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end

    assign cap_wide = CMP_W'(capacity_reg);

    always_comb begin
        if (cap_wide == '0) begin
            eff_cap = CAP_W'(1);
        end else if (cap_wide > CMP_W'(MAX_CAPACITY)) begin
            eff_cap = CAP_W'(MAX_CAPACITY);
        end else begin
            eff_cap = cap_wide[CAP_W-1:0];
        end
    end

    // Launch a lookup: the key itself is the first value pushed into slot 0
    assign s_ready = advance;

    always_comb begin
        wave_chain[0].active    = s_valid;
        wave_chain[0].key       = s_vertex_index;
        wave_chain[0].carry     = s_vertex_index;
        wave_chain[0].carry_vld = 1'b1;
        wave_chain[0].found     = 1'b0;
        wave_chain[0].last      = s_last_in_buffer;
        pos_chain[0]            = '0;
    end

    // Row of cache slots, most recent at slot 0
    for (genvar i = 0; i < MAX_CAPACITY; i++) begin : g_cell
        lvc_cell #(
            .MAX_CAPACITY (MAX_CAPACITY),
            .CELL_IDX     (i),
            .CAP_W        (CAP_W),
            .POS_W        (POS_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .eff_cap (eff_cap),
            .wave_i  (wave_chain[i]),
            .pos_i   (pos_chain[i]),
            .wave_o  (wave_chain[i+1]),
            .pos_o   (pos_chain[i+1])
        );
    end

    // Count and present the finished lookup
    lvc_tally #(
        .POS_W (POS_W)
    ) u_tally (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wave_i         (wave_chain[MAX_CAPACITY]),
        .pos_i          (pos_chain[MAX_CAPACITY]),
        .advance        (advance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_hit_position (m_hit_position),
        .m_hit_total    (m_hit_total),
        .m_miss_total   (m_miss_total),
        .m_is_last      (m_is_last)
    );

endmodule

// ===== design/lvc_checker.sv =====
// ----------------------------------------------------------------------------
// lvc_checker: port-level checks for the LRU vertex cache simulator
// Watches the top level's channels and flags broken result ordering or
// stalling behaviour.
// ----------------------------------------------------------------------------
module lvc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_hit,
    input logic [lvc_pkg::POS_OUT_W-1:0] m_hit_position,
    input logic [lvc_pkg::CNT_W-1:0]     m_hit_total,
    input logic [lvc_pkg::CNT_W-1:0]     m_miss_total,
    input logic                          m_is_last
);

    // Hold a stalled result beat
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_total) &&
        $stable(m_miss_total) && $stable(m_hit) && $stable(m_hit_position) &&
        $stable(m_is_last))
        else $error("result beat changed while stalled");

    // A stalled result stops the input side
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while result stalled");

    // A miss reports slot zero
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_hit_position == '0)
        else $error("miss with nonzero position");

    // Within a buffer the hit count never drops between back-to-back beats
    a_hits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_is_last ##1 m_valid |->
        m_hit_total >= $past(m_hit_total))
        else $error("hit count dropped within a buffer");

    // Likewise the miss count
    a_misses_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_is_last ##1 m_valid |->
        m_miss_total >= $past(m_miss_total))
        else $error("miss count dropped within a buffer");

endmodule

bind lru_vertex_cache_sim_top lvc_checker u_lvc_checker (.*);

// ===== sim/lru_vertex_cache_sim_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_vertex_cache_sim_checker: result predictor and scoreboard
// Watches the capacity, lookup and result channels, keeps its own copy of the
// move-to-front cache and counters, and compares every result beat with the
// oldest predicted lookup.
// ----------------------------------------------------------------------------
module lru_vertex_cache_sim_checker #(
    parameter int MAX_CAPACITY = lvc_pkg::MAX_CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lvc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [lvc_pkg::KEY_W-1:0]     s_vertex_index,
    input  logic                          s_last_in_buffer,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_hit,
    input  logic [lvc_pkg::POS_OUT_W-1:0] m_hit_position,
    input  logic [lvc_pkg::CNT_W-1:0]     m_hit_total,
    input  logic [lvc_pkg::CNT_W-1:0]     m_miss_total,
    input  logic                          m_is_last,
    output int                            mismatch_count,
    output int                            lookups_in_flight
);
    import lvc_pkg::*;

    typedef struct packed {
        logic                 hit;
        logic [POS_OUT_W-1:0] position;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
        logic                 is_last;
    } lookup_result_t;

    logic [KEY_W-1:0] slot_key [MAX_CAPACITY];
    int unsigned      fill_count;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CFG_W-1:0] capacity;
    lookup_result_t   expected_lookups [$];

    function automatic void empty_cache();
        for (int j = 0; j < MAX_CAPACITY; j++) begin
            slot_key[j] = '1;
        end
        fill_count = 0;
        hit_count  = '0;
        miss_count = '0;
    endfunction

    // Move-to-front lookup: returns the result beat and updates the cache.
    function automatic lookup_result_t lookup_vertex(input logic [KEY_W-1:0] key,
                                                     input logic is_last);
        int unsigned    cap_eff;
        int unsigned    slot;
        int unsigned    shift_top;
        logic           found;
        lookup_result_t res;
        cap_eff = (capacity == 0) ? 1 :
                  ((capacity > MAX_CAPACITY) ? MAX_CAPACITY : capacity);
        // entries beyond a reduced capacity are forgotten
        if (fill_count > cap_eff) fill_count = cap_eff;
        found = 1'b0;
        slot  = 0;
        for (int unsigned j = 0; j < fill_count; j++) begin
            if (!found && slot_key[j] == key) begin
                found = 1'b1;
                slot  = j;
            end
        end
        if (found) begin
            for (int j = slot; j > 0; j--) slot_key[j] = slot_key[j-1];
            if (hit_count != COUNT_MAX) hit_count++;
        end else begin
            shift_top = (fill_count < cap_eff) ? fill_count : cap_eff - 1;
            for (int j = shift_top; j > 0; j--) slot_key[j] = slot_key[j-1];
            if (fill_count < cap_eff) fill_count++;
            if (miss_count != COUNT_MAX) miss_count++;
        end
        slot_key[0]    = key;
        res.hit        = found;
        res.position   = found ? POS_OUT_W'(slot) : '0;
        res.hit_total  = hit_count;
        res.miss_total = miss_count;
        res.is_last    = is_last;
        if (is_last) empty_cache();
        return res;
    endfunction

    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            empty_cache();
            capacity = CAPACITY_RESET;
            expected_lookups.delete();
            mismatch_count    = 0;
            lookups_in_flight = 0;
        end else begin
            if (cfg_valid && cfg_ready) capacity = cfg_data;
            if (m_valid && m_ready) begin
                if (expected_lookups.size() == 0) begin
                    $error("result beat with no lookup outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_hit);
                        mismatch_count++;
                    end
                    if (m_hit_position !== want.position) begin
                        $error("hit_position: expected %0d, got %0d",
                               want.position, m_hit_position);
                        mismatch_count++;
                    end
                    if (m_hit_total !== want.hit_total) begin
                        $error("hit_total: expected %0d, got %0d",
                               want.hit_total, m_hit_total);
                        mismatch_count++;
                    end
                    if (m_miss_total !== want.miss_total) begin
                        $error("miss_total: expected %0d, got %0d",
                               want.miss_total, m_miss_total);
                        mismatch_count++;
                    end
                    if (m_is_last !== want.is_last) begin
                        $error("is_last: expected %0d, got %0d", want.is_last, m_is_last);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_lookups.push_back(lookup_vertex(s_vertex_index, s_last_in_buffer));
            end
            lookups_in_flight = expected_lookups.size();
        end
    end

endmodule

// ===== sim/lru_vertex_cache_sim_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_vertex_cache_sim_top_tb: testbench for the LRU vertex cache simulator
// Drives a directed burst of lookups covering empty slots, eviction, the
// all-ones index, buffer ends and capacity cuts, then random lookup streams
// drawn from small key pools over a sweep of capacities. A separate checker
// predicts every result beat; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module lru_vertex_cache_sim_top_tb;
    import lvc_pkg::*;

    localparam int MAX_CAPACITY = MAX_CAPACITY_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 42;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_valid        = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data         = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [KEY_W-1:0]     s_vertex_index   = '0;
    logic                 s_last_in_buffer = 1'b0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic                 m_hit;
    logic [POS_OUT_W-1:0] m_hit_position;
    logic [CNT_W-1:0]     m_hit_total;
    logic [CNT_W-1:0]     m_miss_total;
    logic                 m_is_last;

    int mismatch_count;
    int lookups_in_flight;
    int cycle_count = 0;

    // set for the stretch where neither side may idle
    logic no_idle = 1'b0;

    // capacity per random phase: extremes, above-range values and a spread
    logic [CFG_W-1:0] phase_caps [PHASE_COUNT] = '{
        8'd255, 8'd128, 8'd1, 8'd0, 8'd2, 8'd16,
        8'd200, 8'd64, 8'd5, 8'd127, 8'd3, 8'd32
    };

    lru_vertex_cache_sim_top #(
        .MAX_CAPACITY    (MAX_CAPACITY)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_vertex_index  (s_vertex_index),
        .s_last_in_buffer(s_last_in_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_hit_position  (m_hit_position),
        .m_hit_total     (m_hit_total),
        .m_miss_total    (m_miss_total),
        .m_is_last       (m_is_last)
    );

    lru_vertex_cache_sim_checker #(
        .MAX_CAPACITY     (MAX_CAPACITY)
    ) results_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vertex_index   (s_vertex_index),
        .s_last_in_buffer (s_last_in_buffer),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_hit_position   (m_hit_position),
        .m_hit_total      (m_hit_total),
        .m_miss_total     (m_miss_total),
        .m_is_last        (m_is_last),
        .mismatch_count   (mismatch_count),
        .lookups_in_flight(lookups_in_flight)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run, drains and stalls included.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lru_vertex_cache_sim_top_tb: errors");
            $finish;
        end
    end

    // Result side: back-pressure with a probability of about 28 percent, except
    // in the no-idle stretch.
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= 28);
    end

    // Offer one lookup beat, with random idle cycles ahead of it. Valid stays
    // high across back-to-back beats; return at the falling edge after the
    // beat is taken.
    task automatic push_vertex(input logic [KEY_W-1:0] key, input logic end_of_buffer);
        while (!no_idle && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_vertex_index   <= key;
        s_last_in_buffer <= end_of_buffer;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every predicted result has been seen.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (lookups_in_flight != 0) @(negedge aclk);
    endtask

    // Write the capacity only with no lookup in flight.
    task automatic set_capacity(input logic [CFG_W-1:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly keys from a pool a little larger than the cache, so hits are
    // common; now and then a full-range key or the all-ones index.
    function automatic logic [KEY_W-1:0] pick_vertex(input int unsigned base,
                                                     input int unsigned span);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return KEY_W'($urandom_range(0, 65535));
        if (roll < 12) return '1;
        return KEY_W'(base + $urandom_range(0, span - 1));
    endfunction

    initial begin
        int unsigned cap_eff;
        int unsigned span;
        int unsigned base;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed: three-slot cache ------------------------------------
        set_capacity(8'd3);
        push_vertex(16'h0000, 1'b0);      // miss into an empty cache
        push_vertex(16'hFFFF, 1'b0);      // all-ones must not match an empty slot
        push_vertex(16'h0000, 1'b0);      // hit one slot back
        push_vertex(16'hFFFF, 1'b0);      // hit one slot back again
        push_vertex(16'h0001, 1'b0);      // fills the cache
        push_vertex(16'h0000, 1'b0);      // hit in the oldest slot
        push_vertex(16'h0002, 1'b0);      // miss on a full cache: evict the oldest
        push_vertex(16'hFFFF, 1'b0);      // evicted, so a miss
        push_vertex(16'hFFFF, 1'b0);      // hit at the front
        push_vertex(16'h0001, 1'b1);      // buffer end: counts final, then clear
        push_vertex(16'h0001, 1'b0);      // fresh buffer: miss from zero counts
        push_vertex(16'h5555, 1'b0);
        push_vertex(16'hAAAA, 1'b0);

        // ---- directed: capacity cut mid-buffer ----------------------------
        set_capacity(8'd1);
        push_vertex(16'h0001, 1'b0);      // beyond the new capacity: forgotten
        push_vertex(16'h0001, 1'b0);      // hit at the front
        push_vertex(16'hAAAA, 1'b0);      // single slot replaced

        // ---- directed: zero capacity behaves as one slot ------------------
        set_capacity(8'd0);
        push_vertex(16'hAAAA, 1'b0);
        push_vertex(16'h5555, 1'b1);

        // ---- random phases ---------------------------------------------
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_capacity(phase_caps[p]);
            no_idle = (p == 5);
            cap_eff = (phase_caps[p] == 0) ? 1 :
                      ((phase_caps[p] > MAX_CAPACITY) ? MAX_CAPACITY : phase_caps[p]);
            span = cap_eff + cap_eff / 2 + 2;
            base = $urandom_range(0, 65535 - span);

            // Full-depth sweep: close the buffer, fill every slot with distinct
            // keys, then hit the oldest one in the last slot.
            if (cap_eff == MAX_CAPACITY && phase_caps[p] == MAX_CAPACITY) begin
                push_vertex(pick_vertex(base, span), 1'b1);
                for (int k = 0; k < MAX_CAPACITY; k++) begin
                    push_vertex(KEY_W'(base + k), 1'b0);
                end
                push_vertex(KEY_W'(base), 1'b0);
            end

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                push_vertex(pick_vertex(base, span), $urandom_range(0, 39) == 0);
            end
            no_idle = 1'b0;
        end

        // Drain, then let the row settle for a full pass before the verdict.
        wait_for_results();
        repeat (MAX_CAPACITY + 16) @(negedge aclk);
        if (mismatch_count == 0 && lookups_in_flight == 0) begin
            $display("lru_vertex_cache_sim_top_tb: clean");
        end else begin
            $display("lru_vertex_cache_sim_top_tb: errors");
        end
        $finish;
    end

endmodule
